[design/hsc_pkg.sv]
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared types, codes and code-layout functions for the SECDED codec.
// ----------------------------------------------------------------------------
package hsc_pkg;

    localparam int DATA_BITS = 57;
    localparam int CODE_BITS = 64;
    localparam int SYN_BITS  = 6;
    localparam int LEN_BITS  = 6;

    localparam logic [LEN_BITS-1:0] LEN_RESET = 6'd8;

    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SINGLE = 2'd1;
    localparam logic [1:0] ST_DOUBLE = 2'd2;
    localparam logic [1:0] ST_UNCORR = 2'd3;

    typedef struct packed {
        logic [SYN_BITS-1:0]  code_len;
        logic [CODE_BITS-1:0] pos_mask;
    } cfg_t;

    typedef struct packed {
        logic [CODE_BITS-1:0] word;
        logic [SYN_BITS-1:0]  syndrome;
        logic                 parity_fail;
        logic [1:0]           status;
    } result_t;

    // smallest p with d < 2^p - p, capped at 7
    function automatic int check_count(int d);
        int p;
        p = 0;
        for (int i = 0; i < 7; i++)
        begin
            if (d >= (1 << p) - p)
                p = p + 1;
        end
        return p;
    endfunction

    // code length n for a requested data length, clamped to fit max_bits
    function automatic logic [SYN_BITS-1:0] eff_code_len(logic [LEN_BITS-1:0] len,
                                                        int max_bits);
        int d;
        int best;
        d    = (len == '0) ? 1 : int'(len);
        best = 1 + check_count(1);
        for (int c = 1; c < 64; c++)
        begin
            if (c <= d && c + check_count(c) + 1 <= max_bits)
                best = c + check_count(c);
        end
        return best[SYN_BITS-1:0];
    endfunction

    function automatic logic [CODE_BITS-1:0] pos_mask_of(logic [SYN_BITS-1:0] n);
        logic [CODE_BITS-1:0] m;
        for (int i = 0; i < CODE_BITS; i++)
            m[i] = (i <= int'(n));
        return m;
    endfunction

    function automatic bit is_data_pos(int m);
        return (m >= 3) && ((m & (m - 1)) != 0);
    endfunction

    // data bit index held at a data position
    function automatic int data_index(int m);
        int k;
        k = 0;
        for (int j = 3; j < CODE_BITS; j++)
        begin
            if (j < m && is_data_pos(j))
                k = k + 1;
        end
        return k;
    endfunction

    // positions whose index has bit i set
    function automatic logic [CODE_BITS-1:0] pos_bit_mask(int i);
        logic [CODE_BITS-1:0] m;
        for (int j = 0; j < CODE_BITS; j++)
            m[j] = ((j >> i) & 1) != 0;
        return m;
    endfunction

endpackage

[design/hsc_cfg.sv]
// ----------------------------------------------------------------------------
// hsc_cfg
// Data length register; holds the derived code length and position mask.
// ----------------------------------------------------------------------------
module hsc_cfg #(
    parameter int MAX_CODE_BITS = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [hsc_pkg::LEN_BITS-1:0] cfg_wr_data,
    output hsc_pkg::cfg_t                cfg
);

    localparam logic [hsc_pkg::SYN_BITS-1:0] LEN_RST =
        hsc_pkg::eff_code_len(hsc_pkg::LEN_RESET, MAX_CODE_BITS);
    localparam logic [hsc_pkg::CODE_BITS-1:0] MASK_RST = hsc_pkg::pos_mask_of(LEN_RST);

    logic [hsc_pkg::SYN_BITS-1:0]  code_len_reg;
    logic [hsc_pkg::SYN_BITS-1:0]  code_len_next;
    logic [hsc_pkg::CODE_BITS-1:0] pos_mask_reg;
    logic [hsc_pkg::CODE_BITS-1:0] pos_mask_next;

    always_comb
    begin
        code_len_next = hsc_pkg::eff_code_len(cfg_wr_data, MAX_CODE_BITS);
        pos_mask_next = hsc_pkg::pos_mask_of(code_len_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_len_reg <= LEN_RST;
            pos_mask_reg <= MASK_RST;
        end
        else if (cfg_wr_en)
        begin
            code_len_reg <= code_len_next;
            pos_mask_reg <= pos_mask_next;
        end
    end

    assign cfg.code_len = code_len_reg;
    assign cfg.pos_mask = pos_mask_reg;

endmodule

[design/hsc_core.sv]
// ----------------------------------------------------------------------------
// hsc_core
// Single-pass encode / decode datapath: XOR trees, correction and status.
// ----------------------------------------------------------------------------
module hsc_core (
    input  hsc_pkg::cfg_t                 cfg,
    input  logic                          func,
    input  logic [hsc_pkg::DATA_BITS-1:0] data_word,
    input  logic [hsc_pkg::CODE_BITS-1:0] code_word,
    output hsc_pkg::result_t              res
);

    logic [hsc_pkg::CODE_BITS-1:0] scattered;
    logic [hsc_pkg::CODE_BITS-1:0] enc_data;
    logic [hsc_pkg::CODE_BITS-1:0] enc_word;
    logic [hsc_pkg::SYN_BITS-1:0]  enc_syn;
    logic [hsc_pkg::CODE_BITS-1:0] dec_in;
    logic [hsc_pkg::SYN_BITS-1:0]  dec_syn;
    logic                          dec_pf;
    logic [hsc_pkg::CODE_BITS-1:0] dec_flip;

    // data bits to their code positions
    for (genvar m = 0; m < hsc_pkg::CODE_BITS; m++)
    begin : g_place
        if (hsc_pkg::is_data_pos(m))
        begin : g_data
            assign scattered[m] = data_word[hsc_pkg::data_index(m)];
        end
        else
        begin : g_hole
            assign scattered[m] = 1'b0;
        end
    end

    assign enc_data = scattered & cfg.pos_mask;
    assign dec_in   = code_word & cfg.pos_mask;

    for (genvar i = 0; i < hsc_pkg::SYN_BITS; i++)
    begin : g_syn
        localparam logic [hsc_pkg::CODE_BITS-1:0] SEL = hsc_pkg::pos_bit_mask(i);
        assign enc_syn[i] = ^(enc_data & SEL);
        assign dec_syn[i] = ^(dec_in & SEL);
    end

    always_comb
    begin
        enc_word = enc_data;
        for (int i = 0; i < hsc_pkg::SYN_BITS; i++)
            enc_word[1 << i] = enc_syn[i];
        enc_word[0] = ^enc_word[hsc_pkg::CODE_BITS-1:1];
    end

    assign dec_pf   = ^dec_in;
    assign dec_flip = {{(hsc_pkg::CODE_BITS-1){1'b0}}, 1'b1} << dec_syn;

    always_comb
    begin
        res = '0;
        case (func)
            hsc_pkg::FUNC_ENCODE:
            begin
                res.word = enc_word;
            end
            hsc_pkg::FUNC_DECODE:
            begin
                res.word        = dec_in;
                res.syndrome    = dec_syn;
                res.parity_fail = dec_pf;
                if (dec_pf)
                begin
                    if (dec_syn <= cfg.code_len)
                    begin
                        res.word   = dec_in ^ dec_flip;
                        res.status = hsc_pkg::ST_SINGLE;
                    end
                    else
                    begin
                        res.status = hsc_pkg::ST_UNCORR;
                    end
                end
                else if (dec_syn != '0)
                begin
                    res.status = hsc_pkg::ST_DOUBLE;
                end
                else
                begin
                    res.status = hsc_pkg::ST_OK;
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule

[design/hamming_secded_codec.sv]
// ----------------------------------------------------------------------------
// hamming_secded_codec
// Extended Hamming SECDED encoder / decoder with configurable data length.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register. Throughput: one transfer per
// cycle while out_stall does not hold the pipeline, set by the single XOR-tree
// pass between the two registers.
// Reset: pipeline empty, data length 8.
// ----------------------------------------------------------------------------
module hamming_secded_codec #(
    parameter int MAX_CODE_BITS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [hsc_pkg::LEN_BITS-1:0]  cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          func,
    input  logic [hsc_pkg::DATA_BITS-1:0] data_word,
    input  logic [hsc_pkg::CODE_BITS-1:0] code_word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [hsc_pkg::CODE_BITS-1:0] out_word,
    output logic [hsc_pkg::SYN_BITS-1:0]  syndrome,
    output logic                          parity_fail,
    output logic [1:0]                    status
);

    hsc_pkg::cfg_t    cfg;
    hsc_pkg::result_t core_res;

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic                          s1_func_reg;
    logic [hsc_pkg::DATA_BITS-1:0] s1_data_reg;
    logic [hsc_pkg::CODE_BITS-1:0] s1_code_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    hsc_pkg::result_t              s2_res_reg;
    logic                          s1_load;
    logic                          s2_load;

    hsc_cfg #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    hsc_core u_core (
        .cfg       (cfg),
        .func      (s1_func_reg),
        .data_word (s1_data_reg),
        .code_word (s1_code_reg),
        .res       (core_res)
    );

    assign s2_load  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s2_load;
    assign s1_load  = in_valid && !in_stall;

    assign s1_valid_next  = s2_load ? in_valid : (s1_valid_reg || in_valid);
    assign out_valid_next = s2_load ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_func_reg <= func;
            s1_data_reg <= data_word;
            s1_code_reg <= code_word;
        end
        if (s2_load && s1_valid_reg)
            s2_res_reg <= core_res;
    end

    assign out_valid   = out_valid_reg;
    assign out_word    = s2_res_reg.word;
    assign syndrome    = s2_res_reg.syndrome;
    assign parity_fail = s2_res_reg.parity_fail;
    assign status      = s2_res_reg.status;

    a_single_has_parity: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == hsc_pkg::ST_SINGLE |-> parity_fail)
        else $error("single correction without parity failure");

    a_double_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == hsc_pkg::ST_DOUBLE |-> !parity_fail && syndrome != '0)
        else $error("double error flag inconsistent");

    a_uncorr_beyond: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == hsc_pkg::ST_UNCORR |->
            parity_fail && syndrome > cfg.code_len)
        else $error("uncorrectable flag with syndrome inside code");

    a_word_in_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word & ~cfg.pos_mask) == '0)
        else $error("result bits beyond code length");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled with room in pipeline");

endmodule
